@@ rtl/scds_pkg.sv @@
// Shared types and constants for the SPI clock divider search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package scds_pkg;

	localparam int CLK_W   = 28;           // input clock register width
	localparam int REQ_W   = 32;           // requested rate width
	localparam int DEN_W   = 40;           // m * requested rate, m up to 256
	localparam int M_W     = 9;            // multiplier 1..256
	localparam int ACH_W   = 27;           // achieved rate width
	localparam int PS_W    = 8;            // prescale / rate field width
	localparam int OUT_W   = 48;           // result tdata, padded to bytes
	localparam int STEP_W  = $clog2(CLK_W);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(100000000);
	localparam logic [M_W-1:0]   M_FIRST   = M_W'(1);
	localparam logic [M_W-1:0]   M_MAX     = M_W'(256);
	localparam logic [CLK_W-1:0] Q_LIMIT   = CLK_W'(255);
	localparam logic [CLK_W-1:0] P_MIN     = CLK_W'(2);
	localparam logic [CLK_W-1:0] P_MAX     = CLK_W'(254);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FMUL,
		ST_FDIV_GO,
		ST_FDIV_WAIT,
		ST_EMIT
	} scds_state_t;

	// Divider handshake back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} scds_div_stat_t;

endpackage

`default_nettype wire

@@ rtl/scds_divider.sv @@
// Shared restoring divider: CLK_W-bit dividend by DEN_W-bit divisor, one bit a cycle.
// Depends on scds_pkg.
`default_nettype none

module scds_divider
	import scds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CLK_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output scds_div_stat_t        stat,
	output logic [CLK_W-1:0]      quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CLK_W-1:0]  rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;

	logic [CLK_W:0]    trial;
	logic              fits;
	logic [CLK_W:0]    diff;
	logic [CLK_W-1:0]  rem_next;

	// remainder stays below divisor and below 2^CLK_W, so CLK_W bits hold it
	assign trial    = {rem_q, quo_q[CLK_W-1]};
	assign fits     = {{(DEN_W-CLK_W-1){1'b0}}, trial} >= den_q;
	assign diff     = trial - den_q[CLK_W:0];
	assign rem_next = fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(CLK_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

@@ rtl/spi_clock_divider_search.sv @@
// SPI clock divider search: top level with the search sequencer and result cache.
// Depends on scds_pkg and scds_divider.
//
// Usage:
//  - cfg_wr_en / cfg_wr_data load the input clock in hertz (reset 100 MHz).
//    A write clears the cached result. Write only while the block is idle.
//  - s_axis carries one requested bit rate per request (tdata = requested_hz).
//    s_axis_tready is high only while the sequencer is idle.
//  - m_axis returns one result per request: prescale, rate field (m-1),
//    achieved rate and the out-of-range flag.
//  - A request equal to the cached one is answered from the cache, going straight to the emit state.
//  - Otherwise m runs from 1 upward; each trial is a 9x32 multiply and a
//    restoring division on the shared divider. A final prescale*m division
//    gives the achieved rate. The worst case is 256 trials; the trial loop
//    on the divider sets it.
//  - A zero request skips the search (m = 256, flag set), unless it matches the cleared cache after reset or a write.
//  - The result sits in an output register; a new request is taken while it
//    waits. If the receiver stalls, a finished search waits in the emit state
//    until the output register frees up.
//  - Reset clears the cache and the output valid, and sets the clock to 100 MHz.
`default_nettype none

module spi_clock_divider_search
	import scds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CLK_W-1:0] cfg_wr_data,   // input_clock_hz
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [REQ_W-1:0] s_axis_tdata,  // [31:0] requested_hz
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata   // [7:0] prescale_divisor,
	                                             // [15:8] rate_field,
	                                             // [42:16] achieved_hz,
	                                             // [43] out_of_range, [47:44] zero
);

	scds_state_t state_q, state_d;

	logic [CLK_W-1:0] clk_hz_q;
	logic [REQ_W-1:0] req_q;
	logic [M_W-1:0]   m_q;
	logic [DEN_W-1:0] prod_q;
	logic [PS_W-1:0]  ps_q;
	logic             found_q;

	// cache
	logic [REQ_W-1:0] c_req_q;
	logic [ACH_W-1:0] c_ach_q;
	logic [PS_W-1:0]  c_ps_q;
	logic [PS_W-1:0]  c_rate_q;
	logic             c_flag_q;

	logic [OUT_W-1:0] out_q;
	logic             out_vld_q;

	logic             in_acc;
	logic             out_free;
	logic             div_start;
	scds_div_stat_t   div_stat;
	logic [CLK_W-1:0] div_quo;

	logic [CLK_W-1:0] p_clamp;
	logic [PS_W-1:0]  p_even;
	logic             q_fits;
	logic [M_W-1:0]   m_less;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign q_fits   = div_quo < Q_LIMIT;
	assign m_less   = m_q - M_FIRST;

	// clamp to 2..254 then round up to even; a quotient of 255 or more becomes 254
	always_comb begin
		priority if (div_quo < P_MIN) begin
			p_clamp = P_MIN;
		end else if (div_quo > P_MAX) begin
			p_clamp = P_MAX;
		end else begin
			p_clamp = div_quo;
		end
		p_even = (p_clamp[PS_W-1:0] + PS_W'(1)) & ~PS_W'(1);
	end

	scds_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clk_hz_q),
		.divisor  (prod_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					priority if (s_axis_tdata == c_req_q) begin
						state_d = ST_EMIT;
					end else if (s_axis_tdata == '0) begin
						state_d = ST_FMUL;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL:      state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					if (q_fits || m_q == M_MAX) begin
						state_d = ST_FMUL;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_FMUL:     state_d = ST_FDIV_GO;
			ST_FDIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_FDIV_WAIT;
			end
			ST_FDIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// search datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					req_q <= s_axis_tdata;
					if (s_axis_tdata == '0) begin
						m_q     <= M_MAX;
						ps_q    <= P_MAX[PS_W-1:0];
						found_q <= 1'b0;
					end else begin
						m_q <= M_FIRST;
					end
				end
			end
			ST_MUL: begin
				prod_q <= DEN_W'(m_q) * DEN_W'(req_q);
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					if (q_fits || m_q == M_MAX) begin
						ps_q    <= p_even;
						found_q <= q_fits;
					end else begin
						m_q <= m_q + M_FIRST;
					end
				end
			end
			ST_FMUL: begin
				prod_q <= DEN_W'(ps_q) * DEN_W'(m_q);
			end
			default: begin
			end
		endcase
	end

	// config register, cache and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q  <= CLK_RESET;
			c_req_q   <= '0;
			c_ach_q   <= '0;
			c_ps_q    <= '0;
			c_rate_q  <= '0;
			c_flag_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				clk_hz_q <= cfg_wr_data;
				c_req_q  <= '0;
				c_ach_q  <= '0;
				c_ps_q   <= '0;
				c_rate_q <= '0;
				c_flag_q <= 1'b0;
			end else if (state_q == ST_FDIV_WAIT && div_stat.done) begin
				c_req_q  <= req_q;
				c_ach_q  <= div_quo[ACH_W-1:0];
				c_ps_q   <= ps_q;
				c_rate_q <= m_less[PS_W-1:0];
				c_flag_q <= !found_q;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q <= {{(OUT_W-ACH_W-2*PS_W-1){1'b0}}, c_flag_q, c_ach_q, c_rate_q, c_ps_q};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

@@ rtl/scds_checker.sv @@
// Port-level checks for spi_clock_divider_search, attached by bind.
// Depends on scds_pkg.
`default_nettype none

module scds_checker
	import scds_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	// one request at a time: busy right after an accept
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("tready high right after a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// prescale is even and nonzero unless the whole result is the cleared cache
	a_prescale: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[0] && m_axis_tdata[7:0] != 8'd255
			&& (m_axis_tdata[7:0] != 8'd0 || m_axis_tdata[43:8] == 36'd0))
		else $error("bad prescale");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[43] |->
			m_axis_tdata[15:8] == 8'd255 && m_axis_tdata[7:0] == 8'd254)
		else $error("out-of-range result without saturated divider");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:44] == 4'd0)
		else $error("padding bits set");

endmodule

bind spi_clock_divider_search scds_checker u_scds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
